### design/xor_packet_deframer_resync_top_assert.svh
// ----------------------------------------------------------------------------
// xor_packet_deframer_resync_top_assert.svh
// Assertion macros for the XOR packet deframer.
// ----------------------------------------------------------------------------
`ifndef XOR_PACKET_DEFRAMER_RESYNC_TOP_ASSERT_SVH
`define XOR_PACKET_DEFRAMER_RESYNC_TOP_ASSERT_SVH

// same-cycle implication, suspended during reset
`define XPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// next-cycle implication, suspended during reset
`define XPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

### design/xpd_pkg.sv
// ----------------------------------------------------------------------------
// xpd_pkg
// Shared types and constants of the XOR packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package xpd_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned WINDOW_DEPTH = 4;
  localparam int unsigned FILL_W       = $clog2(WINDOW_DEPTH + 1);

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [FILL_W-1:0] fill_t;

  localparam fill_t FILL_EMPTY = '0;
  localparam fill_t FILL_FULL  = fill_t'(WINDOW_DEPTH);

endpackage

`default_nettype wire

### design/xpd_cell.sv
// ----------------------------------------------------------------------------
// xpd_cell
// One window cell: holds a byte, shifts it on to the older neighbour and
// folds its byte into the running XOR passed along the chain.
// ----------------------------------------------------------------------------
`default_nettype none

module xpd_cell (
  input  wire logic          clk,
  input  wire logic          shift_en,
  input  wire xpd_pkg::byte_t data_in,
  input  wire xpd_pkg::byte_t xor_in,
  output      xpd_pkg::byte_t data_out,
  output      xpd_pkg::byte_t xor_out
);

  xpd_pkg::byte_t data_r;
  xpd_pkg::byte_t data_nxt;

  always_comb begin
    data_nxt = shift_en ? data_in : data_r;
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;
  assign xor_out  = xor_in ^ data_r;

endmodule

`default_nettype wire

### design/xor_packet_deframer_resync_top.sv
// ----------------------------------------------------------------------------
// xor_packet_deframer_resync_top
// Sliding-window XOR checksum packet deframer with byte-wise resync.
// ----------------------------------------------------------------------------
// One received byte is taken every clock cycle unless in_stall is high. The
// four-byte window is a chain of cells that shifts by one byte per accepted
// non-matching byte and ripples the checksum XOR along its length, so a
// candidate checksum is checked combinationally. A matching packet appears on
// the output register in the cycle after its checksum byte is taken; the input
// stalls only while a result sits in the output register and the output stalls.
`default_nettype none

module xor_packet_deframer_resync_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output      logic         in_stall,
  input  wire logic [7:0]   in_rx_byte,
  output      logic         out_valid,
  input  wire logic         out_stall,
  output      logic [7:0]   out_command,
  output      logic [7:0]   out_param_one,
  output      logic [7:0]   out_param_two,
  output      logic [7:0]   out_param_three
);

  localparam int unsigned DEPTH = xpd_pkg::WINDOW_DEPTH;

  xpd_pkg::byte_t win_data [DEPTH+1];
  xpd_pkg::byte_t win_xor  [DEPTH+1];

  xpd_pkg::fill_t fill_r, fill_nxt;
  logic           out_valid_r, out_valid_nxt;
  xpd_pkg::byte_t res_r   [DEPTH];
  xpd_pkg::byte_t res_nxt [DEPTH];

  logic in_fire;
  logic full;
  logic match;
  logic shift_en;

  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;
  assign full     = (fill_r >= xpd_pkg::FILL_FULL);
  assign match    = full && (win_xor[DEPTH] == xpd_pkg::byte_t'(in_rx_byte));
  assign shift_en = in_fire && !match;

  // cell 0 is the oldest byte; new bytes enter at the top of the chain
  assign win_data[DEPTH] = xpd_pkg::byte_t'(in_rx_byte);
  assign win_xor[0]      = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    xpd_cell u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .data_in  (win_data[i+1]),
      .xor_in   (win_xor[i]),
      .data_out (win_data[i]),
      .xor_out  (win_xor[i+1])
    );
  end

  always_comb begin
    fill_nxt      = fill_r;
    out_valid_nxt = out_valid_r && out_stall;
    for (int i = 0; i < DEPTH; i++) begin
      res_nxt[i] = res_r[i];
    end
    if (in_fire) begin
      if (match) begin
        fill_nxt      = xpd_pkg::FILL_EMPTY;
        out_valid_nxt = 1'b1;
        for (int i = 0; i < DEPTH; i++) begin
          res_nxt[i] = win_data[i];
        end
      end else if (full) begin
        fill_nxt = xpd_pkg::FILL_FULL;
      end else begin
        fill_nxt = fill_r + xpd_pkg::fill_t'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= xpd_pkg::FILL_EMPTY;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      res_r[i] <= res_nxt[i];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_command     = res_r[0];
  assign out_param_one   = res_r[1];
  assign out_param_two   = res_r[2];
  assign out_param_three = res_r[3];

`include "xor_packet_deframer_resync_top_assert.svh"

  `XPD_ASSERT_NOW(a_fill_range, clk, rst_n, 1'b1, fill_r <= xpd_pkg::FILL_FULL)
  `XPD_ASSERT_NOW(a_stall_only_held, clk, rst_n, in_stall, out_valid_r)
  `XPD_ASSERT_NEXT(a_match_emits, clk, rst_n, in_fire && match, out_valid_r && fill_r == xpd_pkg::FILL_EMPTY)
  `XPD_ASSERT_NEXT(a_resync_stays_full, clk, rst_n, in_fire && full && !match, fill_r == xpd_pkg::FILL_FULL)

endmodule

`default_nettype wire
